// ----- rtl/abrb_pkg.sv -----
// ----------------------------------------------------------------------------
// abrb_pkg
// Shared types, constants and helpers of the alpha blend rectangle blitter.
// ----------------------------------------------------------------------------
package abrb_pkg;

	localparam int PIX_W         = 32;
	localparam int CH_W          = 8;
	localparam int NUM_CH        = 3;
	localparam int OFF_W         = 24;
	localparam int STRIDE_W      = 16;
	localparam int RECT_W        = 13;
	localparam int PIXEL_BYTES   = 4;
	localparam int PB_SHIFT      = $clog2(PIXEL_BYTES);
	localparam int PROD_W        = 2 * CH_W;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int FIFO_DEPTH    = 4;
	localparam int BACK_STAGES   = 2;
	localparam int DEF_MAX_DIM   = 4096;
	localparam int DEF_ADDR_BITS = 24;

	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLEND_MODE  = 3'd0,
		REG_FILL_COLOR  = 3'd1,
		REG_DST_START   = 3'd2,
		REG_DST_STRIDE  = 3'd3,
		REG_SRC_START   = 3'd4,
		REG_SRC_STRIDE  = 3'd5,
		REG_RECT_WIDTH  = 3'd6,
		REG_RECT_HEIGHT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                blend_mode;
		logic [PIX_W-1:0]    fill_color;
		logic [OFF_W-1:0]    dst_start;
		logic [STRIDE_W-1:0] dst_stride;
		logic [OFF_W-1:0]    src_start;
		logic [STRIDE_W-1:0] src_stride;
		logic [RECT_W-1:0]   rect_width;
		logic [RECT_W-1:0]   rect_height;
	} cfg_regs_t;

	// pixel part of a queued item, counters travel beside it
	typedef struct packed {
		logic [PIX_W-1:0] dst_pixel;
		logic [PIX_W-1:0] color;
		logic             mode;
		logic             last;
	} pix_item_t;

	// exact x/255 for x up to 255*255
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W-1:0] t;
		t = x + {{CH_W{1'b0}}, x[PROD_W-1:CH_W]} + PROD_W'(1);
		return t[PROD_W-1:CH_W];
	endfunction

endpackage

// ----- rtl/abrb_cfg.sv -----
// ----------------------------------------------------------------------------
// abrb_cfg
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
module abrb_cfg
	import abrb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;
	cfg_reg_t  idx;

	assign cfg_ready = 1'b1;
	assign idx       = cfg_reg_t'(cfg_index);
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.blend_mode  <= 1'b0;
			regs_q.fill_color  <= '0;
			regs_q.dst_start   <= '0;
			regs_q.dst_stride  <= '0;
			regs_q.src_start   <= '0;
			regs_q.src_stride  <= '0;
			regs_q.rect_width  <= RECT_W'(1);
			regs_q.rect_height <= RECT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (idx)
				REG_BLEND_MODE:  regs_q.blend_mode  <= cfg_data[0];
				REG_FILL_COLOR:  regs_q.fill_color  <= cfg_data[PIX_W-1:0];
				REG_DST_START:   regs_q.dst_start   <= cfg_data[OFF_W-1:0];
				REG_DST_STRIDE:  regs_q.dst_stride  <= cfg_data[STRIDE_W-1:0];
				REG_SRC_START:   regs_q.src_start   <= cfg_data[OFF_W-1:0];
				REG_SRC_STRIDE:  regs_q.src_stride  <= cfg_data[STRIDE_W-1:0];
				REG_RECT_WIDTH:  regs_q.rect_width  <= cfg_data[RECT_W-1:0];
				REG_RECT_HEIGHT: regs_q.rect_height <= cfg_data[RECT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/abrb_front.sv -----
// ----------------------------------------------------------------------------
// abrb_front
// Accepts pixel items, picks the source colour and walks the rectangle.
// ----------------------------------------------------------------------------
module abrb_front
	import abrb_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM,
	parameter int CNT_W   = $clog2(MAX_DIM)
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_regs_t        cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [PIX_W-1:0] dst_pixel,
	input  logic [PIX_W-1:0] src_pixel,
	input  logic             q_full,
	output logic             q_push,
	output pix_item_t        q_item,
	output logic [CNT_W-1:0] q_col,
	output logic [CNT_W-1:0] q_row
);

	localparam int CW = (CNT_W + 1 > RECT_W) ? CNT_W + 1 : RECT_W;
	localparam logic [CW-1:0] DIM_MAX = CW'(MAX_DIM);

	logic [CNT_W-1:0] col_q, row_q;
	logic [CW-1:0]    w_ext, h_ext, w_last, h_last;
	logic             col_end, row_end;

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		w_ext = CW'(cfg.rect_width);
		h_ext = CW'(cfg.rect_height);
		if (w_ext == '0)
			w_last = '0;
		else if (w_ext > DIM_MAX)
			w_last = DIM_MAX - CW'(1);
		else
			w_last = w_ext - CW'(1);
		if (h_ext == '0)
			h_last = '0;
		else if (h_ext > DIM_MAX)
			h_last = DIM_MAX - CW'(1);
		else
			h_last = h_ext - CW'(1);
	end

	assign col_end = CW'(col_q) >= w_last;
	assign row_end = CW'(row_q) >= h_last;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_item.dst_pixel = dst_pixel;
		q_item.color     = cfg.blend_mode ? src_pixel : cfg.fill_color;
		q_item.mode      = cfg.blend_mode;
		q_item.last      = col_end && row_end;
		q_col            = col_q;
		q_row            = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/abrb_fifo.sv -----
// ----------------------------------------------------------------------------
// abrb_fifo
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module abrb_fifo
	import abrb_pkg::*;
#(
	parameter int WIDTH = 8
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = count_q == CNT_W'(FIFO_DEPTH);
	assign rvalid = count_q != '0;
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/abrb_back.sv -----
// ----------------------------------------------------------------------------
// abrb_back
// Two-stage blend and address pipeline feeding the output register.
// ----------------------------------------------------------------------------
module abrb_back
	import abrb_pkg::*;
#(
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	parameter int CNT_W     = 12
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_regs_t              cfg,
	input  logic                   q_valid,
	input  pix_item_t              q_item,
	input  logic [CNT_W-1:0]       q_col,
	input  logic [CNT_W-1:0]       q_row,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [NUM_CH*CH_W-1:0] blended_pixel,
	output logic [OFF_W-1:0]       dst_offset,
	output logic [OFF_W-1:0]       src_offset,
	output logic                   last
);

	localparam int ROW_W = CNT_W + STRIDE_W;

	logic                   v_s1, v_s2, adv1, adv2;
	logic [PROD_W-1:0]      pa_s1 [NUM_CH];
	logic [PROD_W-1:0]      pd_s1 [NUM_CH];
	logic [ROW_W-1:0]       drow_s1, srow_s1;
	logic [CNT_W-1:0]       col_s1;
	logic                   mode_s1, last_s1;
	logic [CH_W-1:0]        alpha;
	logic [ADDR_BITS-1:0]   col_bytes, doff, soff;
	logic [NUM_CH*CH_W-1:0] blend;
	logic [NUM_CH*CH_W-1:0] blend_s2;
	logic [OFF_W-1:0]       doff_s2, soff_s2;
	logic                   last_s2;

	assign adv2  = !v_s2 || m_tready;
	assign adv1  = !v_s1 || adv2;
	assign q_pop = q_valid && adv1;
	assign alpha = q_item.color[PIX_W-1 -: CH_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= q_valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	// stage 1: channel products and row offsets
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				pa_s1[ch] <= alpha * q_item.color[ch*CH_W +: CH_W];
				pd_s1[ch] <= (CH_MAX - alpha) * q_item.dst_pixel[ch*CH_W +: CH_W];
			end
			drow_s1 <= q_row * cfg.dst_stride;
			srow_s1 <= q_row * cfg.src_stride;
			col_s1  <= q_col;
			mode_s1 <= q_item.mode;
			last_s1 <= q_item.last;
		end
	end

	// stage 2: divide by 255 and sum the offsets, wrapping at the address width
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++)
			blend[ch*CH_W +: CH_W] = div255(pa_s1[ch] + pd_s1[ch]);
		col_bytes = ADDR_BITS'({col_s1, {PB_SHIFT{1'b0}}});
		doff      = ADDR_BITS'(cfg.dst_start) + ADDR_BITS'(drow_s1) + col_bytes;
		soff      = ADDR_BITS'(cfg.src_start) + ADDR_BITS'(srow_s1) + col_bytes;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			blend_s2 <= blend;
			doff_s2  <= OFF_W'(doff);
			soff_s2  <= mode_s1 ? OFF_W'(soff) : '0;
			last_s2  <= last_s1;
		end
	end

	assign m_tvalid      = v_s2;
	assign blended_pixel = blend_s2;
	assign dst_offset    = doff_s2;
	assign src_offset    = soff_s2;
	assign last          = last_s2;

endmodule

// ----- rtl/alpha_blend_rect_blitter_unit.sv -----
// ----------------------------------------------------------------------------
// alpha_blend_rect_blitter_unit
// Row-major rectangle blitter blending ARGB8888 pixels, one pixel an item.
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes the eight registers by index; take it only while the
//   blitter is idle. s_tdata carries the destination pixel and the source
//   pixel of each item in rectangle order; m_tdata returns the blended rgb888
//   pixel with its destination and source byte offsets, m_tlast on the final
//   pixel of the rectangle.
//   one item per cycle sustained while m_tready is high. a result passes
//   through the four-entry queue, the multiply stage and then the
//   divide/offset stage, which is the output register.
//   when m_tready is low the output holds, the pipeline stalls behind it and
//   the queue keeps taking items until full; s_tready then drops.
//   reset clears the registers to their defaults (width and height one),
//   the counters to the rectangle origin and empties the pipeline.
// ----------------------------------------------------------------------------
module alpha_blend_rect_blitter_unit
	import abrb_pkg::*;
#(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,  // dst_pixel[31:0], src_pixel[63:32]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [71:0]           m_tdata,  // blended_pixel[23:0], dst_offset[47:24],
	                                        // src_offset[71:48]
	output logic                  m_tlast
);

	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int ITEM_W = $bits(pix_item_t) + 2 * CNT_W;

	cfg_regs_t              regs;
	logic                   q_full, q_push, q_pop, q_valid;
	pix_item_t              f_item, b_item;
	logic [CNT_W-1:0]       f_col, f_row, b_col, b_row;
	logic [ITEM_W-1:0]      q_wdata, q_rdata;
	logic [NUM_CH*CH_W-1:0] blended_pixel;
	logic [OFF_W-1:0]       dst_offset, src_offset;

	abrb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	abrb_front #(
		.MAX_DIM (MAX_DIM),
		.CNT_W   (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (regs),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.dst_pixel (s_tdata[PIX_W-1:0]),
		.src_pixel (s_tdata[2*PIX_W-1:PIX_W]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (f_item),
		.q_col     (f_col),
		.q_row     (f_row)
	);

	assign q_wdata = {f_row, f_col, f_item};
	assign {b_row, b_col, b_item} = q_rdata;

	abrb_fifo #(
		.WIDTH (ITEM_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	abrb_back #(
		.ADDR_BITS (ADDR_BITS),
		.CNT_W     (CNT_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (regs),
		.q_valid       (q_valid),
		.q_item        (b_item),
		.q_col         (b_col),
		.q_row         (b_row),
		.q_pop         (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.blended_pixel (blended_pixel),
		.dst_offset    (dst_offset),
		.src_offset    (src_offset),
		.last          (m_tlast)
	);

	assign m_tdata = {src_offset, dst_offset, blended_pixel};

endmodule

// ----- rtl/abrb_checker.sv -----
// ----------------------------------------------------------------------------
// abrb_checker
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module abrb_checker
	import abrb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast
);

	localparam int CAP   = FIFO_DEPTH + BACK_STAGES;
	localparam int OUT_W = $clog2(CAP + 1);

	logic [OUT_W-1:0] outstanding_q;
	logic             s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// items taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if (s_acc && !m_acc)
			outstanding_q <= outstanding_q + OUT_W'(1);
		else if (m_acc && !s_acc)
			outstanding_q <= outstanding_q - OUT_W'(1);
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result shown during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> outstanding_q != '0)
		else $error("result without an accepted item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OUT_W'(CAP))
		else $error("more items in flight than storage");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> outstanding_q >= OUT_W'(FIFO_DEPTH))
		else $error("input stalled with room in the queue");

endmodule

bind alpha_blend_rect_blitter_unit abrb_checker u_abrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alpha blend rectangle blitter: predicts each
// blended pixel, its byte offsets and the end-of-rectangle flag, and checks
// every output item, with random source gaps and sink stalls outside the quiet run.
// ----------------------------------------------------------------------------
module tb;
	import abrb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int BLIT_DIM     = 4096;

	typedef struct packed {
		logic [23:0] rgb;
		logic [23:0] dst_off;
		logic [23:0] src_off;
		logic        last;
	} blit_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [63:0]           s_tdata;   // dst_pixel[31:0], src_pixel[63:32]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [71:0]           m_tdata;   // blended_pixel[23:0], dst_offset[47:24],
	                                  // src_offset[71:48]
	logic                  m_tlast;

	// shadow of the blitter registers and walk position
	cfg_regs_t   shadow_cfg;
	logic [11:0] cur_col;
	logic [11:0] cur_row;

	blit_out_t pending_pixels[$];

	bit idle_on;
	int errors;
	int n_items;
	int n_results;
	int n_writes;
	int n_rects;
	int cycle_count;
	int stall_left;

	alpha_blend_rect_blitter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] s,
			input logic [7:0] d);
		int unsigned sum;
		sum = a * s + (255 - a) * d;
		return 8'(sum / 255);
	endfunction

	function automatic int unsigned clamp_size(input logic [12:0] v);
		if (v == 0)
			return 1;
		if (v > BLIT_DIM)
			return BLIT_DIM;
		return v;
	endfunction

	task automatic predict_pixel(input logic [31:0] dpix, input logic [31:0] spix);
		logic [31:0] color;
		logic [7:0]  a;
		logic [47:0] dsum;
		logic [47:0] ssum;
		int unsigned w;
		int unsigned h;
		logic        col_end;
		logic        row_end;
		blit_out_t   res;
		color = shadow_cfg.blend_mode ? spix : shadow_cfg.fill_color;
		a = color[31:24];
		res.rgb = {blend_channel(a, color[23:16], dpix[23:16]),
			blend_channel(a, color[15:8], dpix[15:8]),
			blend_channel(a, color[7:0], dpix[7:0])};
		dsum = 48'(shadow_cfg.dst_start) + 48'(cur_row) * 48'(shadow_cfg.dst_stride)
			+ 48'(cur_col) * 48'(PIXEL_BYTES);
		ssum = 48'(shadow_cfg.src_start) + 48'(cur_row) * 48'(shadow_cfg.src_stride)
			+ 48'(cur_col) * 48'(PIXEL_BYTES);
		// offsets wrap at the 24-bit address width
		res.dst_off = dsum[23:0];
		res.src_off = shadow_cfg.blend_mode ? ssum[23:0] : 24'd0;
		w = clamp_size(shadow_cfg.rect_width);
		h = clamp_size(shadow_cfg.rect_height);
		// a counter past a shrunken size wraps on this pixel
		col_end = (cur_col >= w - 1);
		row_end = (cur_row >= h - 1);
		res.last = col_end && row_end;
		pending_pixels.push_back(res);
		if (col_end) begin
			cur_col = '0;
			cur_row = row_end ? 12'd0 : cur_row + 12'd1;
		end else begin
			cur_col = cur_col + 12'd1;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		case (idx)
			REG_BLEND_MODE:  shadow_cfg.blend_mode  = val[0];
			REG_FILL_COLOR:  shadow_cfg.fill_color  = val;
			REG_DST_START:   shadow_cfg.dst_start   = val[23:0];
			REG_DST_STRIDE:  shadow_cfg.dst_stride  = val[15:0];
			REG_SRC_START:   shadow_cfg.src_start   = val[23:0];
			REG_SRC_STRIDE:  shadow_cfg.src_stride  = val[15:0];
			REG_RECT_WIDTH:  shadow_cfg.rect_width  = val[12:0];
			REG_RECT_HEIGHT: shadow_cfg.rect_height = val[12:0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [31:0] dpix, input logic [31:0] spix);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {spix, dpix};
		do
			@(posedge clk);
		while (!s_tready);
		n_items++;
		predict_pixel(dpix, spix);
	endtask

	// wait until the pipeline has emptied before touching registers
	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_rect(input logic mode, input logic [31:0] fill,
			input logic [23:0] dstart, input logic [15:0] dstride,
			input logic [23:0] sstart, input logic [15:0] sstride,
			input logic [12:0] w, input logic [12:0] h);
		settle_pipeline();
		write_reg(REG_BLEND_MODE, {31'd0, mode});
		write_reg(REG_FILL_COLOR, fill);
		write_reg(REG_DST_START, {8'd0, dstart});
		write_reg(REG_DST_STRIDE, {16'd0, dstride});
		write_reg(REG_SRC_START, {8'd0, sstart});
		write_reg(REG_SRC_STRIDE, {16'd0, sstride});
		write_reg(REG_RECT_WIDTH, {19'd0, w});
		write_reg(REG_RECT_HEIGHT, {19'd0, h});
	endtask

	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		p = $urandom;
		case ($urandom_range(0, 5))
			0: p[31:24] = 8'h00;
			1: p[31:24] = 8'hFF;
			default: ;
		endcase
		return p;
	endfunction

	function automatic logic [12:0] rand_size();
		case ($urandom_range(0, 19))
			0: return 13'd0;
			1: return 13'(BLIT_DIM);
			2: return 13'($urandom_range(BLIT_DIM + 1, 8191));
			default: return 13'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic test_reset_defaults();
		// defaults: fill mode, clear fill colour, single pixel rectangle
		send_pixel(32'hFFFF_FFFF, 32'h1234_5678);
		send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	task automatic test_fill_extremes();
		load_rect(1'b0, 32'hFF00_FF00, 24'h000100, 16'd64, 24'h00ABCD, 16'd32, 13'd2, 13'd1);
		send_pixel(32'h00FF_00FF, 32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
		settle_pipeline();
		write_reg(REG_FILL_COLOR, 32'h80FF_0080);
		send_pixel(32'h0000_0000, 32'hDEAD_BEEF);
		send_pixel(32'hFFFF_FFFF, 32'hDEAD_BEEF);
	endtask

	task automatic test_image_mode();
		load_rect(1'b1, 32'h0, 24'h000040, 16'd16, 24'h001000, 16'd24, 13'd3, 13'd2);
		send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
		send_pixel(32'hFFFF_FFFF, 32'hFF00_0000);
		send_pixel(32'h0000_0000, 32'h00FF_FFFF);
		send_pixel(32'h1234_5678, 32'h7F80_40C0);
		send_pixel(32'hAA55_AA55, 32'h01FE_01FE);
	endtask

	task automatic test_offset_wrap();
		load_rect(1'b1, 32'h0, 24'hFFFFF0, 16'hFFFF, 24'hFFFFFC, 16'hFFFF, 13'd3, 13'd2);
		repeat (6) send_pixel(rand_pixel(), rand_pixel());
	endtask

	task automatic test_odd_sizes();
		// zero sizes behave as one pixel
		load_rect(1'b0, 32'h4000_FF00, 24'h000010, 16'd8, 24'h000020, 16'd8, 13'd0, 13'd0);
		send_pixel(rand_pixel(), rand_pixel());
		send_pixel(rand_pixel(), rand_pixel());
		// oversize clamps, then shrink with the walk part way along a row
		load_rect(1'b1, 32'h0, 24'h000000, 16'd16384, 24'h000000, 16'd16384,
			13'h1FFF, 13'h1FFF);
		repeat (3) send_pixel(rand_pixel(), rand_pixel());
		settle_pipeline();
		write_reg(REG_RECT_WIDTH, 32'd2);
		write_reg(REG_RECT_HEIGHT, 32'd1);
		send_pixel(rand_pixel(), rand_pixel());
		send_pixel(rand_pixel(), rand_pixel());
	endtask

	task automatic random_config();
		logic [31:0] v;
		settle_pipeline();
		write_reg(REG_BLEND_MODE, $urandom);
		write_reg(REG_FILL_COLOR, rand_pixel());
		v = $urandom;
		if ($urandom_range(0, 3) == 0)
			v[23:0] = 24'hFFFFC0 | 24'($urandom_range(0, 63));
		write_reg(REG_DST_START, v);
		v = $urandom;
		if ($urandom_range(0, 4) == 0)
			v[15:0] = 16'hFFFF;
		write_reg(REG_DST_STRIDE, v);
		v = $urandom;
		if ($urandom_range(0, 3) == 0)
			v[23:0] = 24'hFFFFC0 | 24'($urandom_range(0, 63));
		write_reg(REG_SRC_START, v);
		v = $urandom;
		if ($urandom_range(0, 4) == 0)
			v[15:0] = 16'hFFFF;
		write_reg(REG_SRC_STRIDE, v);
		v = $urandom;
		v[12:0] = rand_size();
		write_reg(REG_RECT_WIDTH, v);
		v = $urandom;
		v[12:0] = rand_size();
		write_reg(REG_RECT_HEIGHT, v);
	endtask

	task automatic test_random_rects(input int target, input bit quiet);
		int sent;
		int area;
		int n;
		sent = 0;
		idle_on = !quiet;
		while (sent < target) begin
			random_config();
			area = clamp_size(shadow_cfg.rect_width) * clamp_size(shadow_cfg.rect_height);
			if (area > 64)
				n = $urandom_range(3, 20);
			else if ($urandom_range(0, 5) == 0)
				n = $urandom_range(1, area);
			else
				n = area * $urandom_range(1, 3);
			repeat (n) send_pixel(rand_pixel(), rand_pixel());
			sent += n;
		end
	endtask

	task automatic compare_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %06h, got %06h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		blit_out_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (pending_pixels.size() == 0) begin
					errors++;
					$error("unexpected output item %06h", m_tdata[23:0]);
				end else begin
					want = pending_pixels.pop_front();
					compare_field("blended_pixel", want.rgb, m_tdata[23:0]);
					compare_field("dst_offset", want.dst_off, m_tdata[47:24]);
					compare_field("src_offset", want.src_off, m_tdata[71:48]);
					compare_field("last", {23'd0, want.last}, {23'd0, m_tlast});
					if (want.last)
						n_rects++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		idle_on   = 1'b1;
		errors = 0; n_items = 0; n_results = 0; n_writes = 0; n_rects = 0;
		cycle_count = 0;
		stall_left = 0;
		shadow_cfg = '0;
		shadow_cfg.rect_width  = 13'd1;
		shadow_cfg.rect_height = 13'd1;
		cur_col = '0;
		cur_row = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_fill_extremes();
		test_image_mode();
		test_offset_wrap();
		test_odd_sizes();
		test_random_rects(540, 1'b0);
		test_random_rects(60, 1'b1);

		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d pixels sent, %0d output items, %0d rectangles closed",
			n_items, n_results, n_rects);
		$display("tb: %0d register writes across fill and image modes", n_writes);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
